/* rtl/core/fde_pkg.sv */
// shared types and constants for the fat directory entry scanner
package fde_pkg;

   localparam int unsigned COUNT_BITS_DEFAULT = 16;
   localparam int unsigned NAME_BYTES         = 11;
   localparam int unsigned REPORT_BITS        = 16;

   localparam logic [7:0] MARK_DELETED   = 8'hE5;
   localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
   localparam logic [7:0] ATTR_SKIP_MASK = 8'h18;
   localparam logic [7:0] MARK_END       = 8'h00;

   // entry byte positions
   localparam logic [4:0] POS_FIRST    = 5'd0;
   localparam logic [4:0] POS_ATTR     = 5'd11;
   localparam logic [4:0] POS_CLU_HI_0 = 5'd20;
   localparam logic [4:0] POS_CLU_HI_1 = 5'd21;
   localparam logic [4:0] POS_CLU_LO_0 = 5'd26;
   localparam logic [4:0] POS_CLU_LO_1 = 5'd27;
   localparam logic [4:0] POS_SIZE_0   = 5'd28;
   localparam logic [4:0] POS_LAST     = 5'd31;

   // configuration register indexes
   localparam logic [1:0] REG_SEARCH_MODE   = 2'd0;
   localparam logic [1:0] REG_NAME_KEY_LOW  = 2'd1;
   localparam logic [1:0] REG_NAME_KEY_HIGH = 2'd2;
   localparam logic [1:0] REG_TARGET_INDEX  = 2'd3;

   localparam logic [1:0] MODE_FIND_NAME  = 2'd0;
   localparam logic [1:0] MODE_FIND_INDEX = 2'd1;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_END       = 2'd1,
      STATUS_CHAIN_END = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  search_mode;
      logic [63:0] name_key_low;
      logic [23:0] name_key_high;
      logic [15:0] target_index;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] file_count;
      logic [31:0] start_cluster;
      logic [31:0] file_size;
      logic [63:0] name_low;
      logic [23:0] name_high;
   } result_type;

endpackage

/* rtl/core/fat_directory_entry_scan.sv */
// top level of the fat32 short-name directory scanner
// a byte passes from the input register through the scan logic into the result register
// throughput: one byte per cycle while the result slot is free or draining; the scan logic
//   sits between input and result registers, so the per-byte state update is the limiting path
// reset: synchronous, active high; clears scan state, configuration and the valid
//   flags of both pipeline registers; a scan may begin after reset without a start mark
module fat_directory_entry_scan #(
   parameter int unsigned COUNT_BITS = fde_pkg::COUNT_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   // byte stream in
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] data_byte
   input  logic          req_tuser,   // [0] scan_start
   input  logic          req_tlast,   // chain_last
   // results out
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [167:0]  rsp_tdata,   // file_count, start_cluster, file_size, name_low, name_high
   output logic [1:0]    rsp_tuser,   // [1:0] status
   // configuration writes
   input  logic          csr_we,
   input  logic [1:0]    csr_addr,
   input  logic [63:0]   csr_wdata
);

   fde_pkg::cfg_type    cfg;
   fde_pkg::result_type res;
   fde_pkg::result_type rsp_ff;
   logic                res_valid;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       in_last_ff;

   logic rsp_valid_ff;
   logic advance;

   // a byte moves into the scan stage only when the result slot is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
   end

   fde_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fde_scan #(
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step_en    (advance),
      .data_byte  (in_byte_ff),
      .scan_start (in_start_ff),
      .chain_last (in_last_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   // result register: holds until the downstream transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {rsp_ff.name_high, rsp_ff.name_low, rsp_ff.file_size,
                        rsp_ff.start_cluster, rsp_ff.file_count};

endmodule

/* rtl/core/fde_csr.sv */
// configuration registers of the directory scanner
module fde_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [63:0]      csr_wdata,
   output fde_pkg::cfg_type cfg
);

   fde_pkg::cfg_type cfg_ff;
   fde_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            fde_pkg::REG_SEARCH_MODE:   cfg_in.search_mode   = csr_wdata[1:0];
            fde_pkg::REG_NAME_KEY_LOW:  cfg_in.name_key_low  = csr_wdata;
            fde_pkg::REG_NAME_KEY_HIGH: cfg_in.name_key_high = csr_wdata[23:0];
            fde_pkg::REG_TARGET_INDEX:  cfg_in.target_index  = csr_wdata[15:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/fde_scan.sv */
// per-byte scan state and entry decision logic
module fde_scan #(
   parameter int unsigned COUNT_BITS = fde_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  fde_pkg::cfg_type    cfg,
   input  logic                step_en,
   input  logic [7:0]          data_byte,
   input  logic                scan_start,
   input  logic                chain_last,
   output logic                res_valid,
   output fde_pkg::result_type res
);

   localparam int unsigned RW = (COUNT_BITS > fde_pkg::REPORT_BITS) ?
                                COUNT_BITS : fde_pkg::REPORT_BITS;

   // count as reported, limited to 16 bits
   function automatic logic [15:0] report_count(input logic [COUNT_BITS-1:0] c);
      logic [RW-1:0] w;
      w = RW'(c);
      return (w > RW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
   endfunction

   logic [4:0]            pos_ff,     pos_in;
   logic [7:0]            first_ff,   first_in;
   logic [7:0]            attr_ff,    attr_in;
   logic                  keq_ff,     keq_in;
   logic [15:0]           clu_hi_ff,  clu_hi_in;
   logic [15:0]           clu_lo_ff,  clu_lo_in;
   logic [31:0]           size_ff,    size_in;
   logic [7:0]            name_ff [fde_pkg::NAME_BYTES];
   logic [COUNT_BITS-1:0] count_ff,   count_in;
   logic                  fin_ff,     fin_in;

   logic [COUNT_BITS-1:0] count_cur;
   logic                  fin_cur;
   logic                  keq_cur;
   logic [4:0]            pos_cur;
   logic [87:0]           key_all;
   logic [7:0]            key_byte;
   logic                  is_name;
   logic                  skip;
   logic                  hit;
   logic [RW-1:0]         count_ext;
   logic [15:0]           count_rep;
   logic [31:0]           size_full;

   assign key_all   = {cfg.name_key_high, cfg.name_key_low};
   assign pos_cur   = scan_start ? '0 : pos_ff;
   assign count_cur = scan_start ? '0 : count_ff;
   assign fin_cur   = scan_start ? 1'b0 : fin_ff;
   assign keq_cur   = scan_start ? 1'b1 : keq_ff;
   assign is_name   = pos_cur < 5'(fde_pkg::NAME_BYTES);
   assign key_byte  = is_name ? key_all[pos_cur[3:0]*8 +: 8] : 8'h00;

   assign count_ext = RW'(count_cur);
   assign count_rep = report_count(count_cur);

   // size byte 3 arrives with the deciding byte
   assign size_full = {data_byte, size_ff[23:0]};

   assign skip = (first_ff == fde_pkg::MARK_DELETED) ||
                 (attr_ff == fde_pkg::ATTR_LONG_NAME) ||
                 ((attr_ff & fde_pkg::ATTR_SKIP_MASK) != 8'h00);

   always_comb begin
      case (cfg.search_mode)
         fde_pkg::MODE_FIND_NAME:  hit = keq_cur;
         fde_pkg::MODE_FIND_INDEX: hit = count_ext == RW'(cfg.target_index);
         default:                  hit = 1'b0;
      endcase
   end

   always_comb begin
      pos_in    = pos_cur;
      first_in  = first_ff;
      attr_in   = attr_ff;
      keq_in    = keq_cur;
      clu_hi_in = clu_hi_ff;
      clu_lo_in = clu_lo_ff;
      size_in   = size_ff;
      count_in  = count_cur;
      fin_in    = fin_cur;
      res_valid = 1'b0;
      res.status        = fde_pkg::STATUS_CHAIN_END;
      res.file_count    = count_rep;
      res.start_cluster = '0;
      res.file_size     = '0;
      res.name_low      = '0;
      res.name_high     = '0;

      if (!fin_cur) begin
         pos_in = pos_cur + 5'd1;
         if (pos_cur == fde_pkg::POS_FIRST) begin
            first_in = data_byte;
            keq_in   = 1'b1;
         end
         if (is_name && (data_byte != key_byte)) begin
            keq_in = 1'b0;
         end
         case (pos_cur)
            fde_pkg::POS_ATTR:     attr_in         = data_byte;
            fde_pkg::POS_CLU_HI_0: clu_hi_in[7:0]  = data_byte;
            fde_pkg::POS_CLU_HI_1: clu_hi_in[15:8] = data_byte;
            fde_pkg::POS_CLU_LO_0: clu_lo_in[7:0]  = data_byte;
            fde_pkg::POS_CLU_LO_1: clu_lo_in[15:8] = data_byte;
            default: begin
               if (pos_cur >= fde_pkg::POS_SIZE_0) begin
                  size_in[pos_cur[1:0]*8 +: 8] = data_byte;
               end
            end
         endcase

         if ((pos_cur == fde_pkg::POS_FIRST) && (data_byte == fde_pkg::MARK_END)) begin
            fin_in     = 1'b1;
            res_valid  = 1'b1;
            res.status = fde_pkg::STATUS_END;
         end else begin
            if ((pos_cur == fde_pkg::POS_LAST) && !skip) begin
               if (hit) begin
                  fin_in            = 1'b1;
                  res_valid         = 1'b1;
                  res.status        = fde_pkg::STATUS_FOUND;
                  res.start_cluster = {clu_hi_ff, clu_lo_ff};
                  res.file_size     = size_full;
                  res.name_low      = {name_ff[7], name_ff[6], name_ff[5], name_ff[4],
                                       name_ff[3], name_ff[2], name_ff[1], name_ff[0]};
                  res.name_high     = {name_ff[10], name_ff[9], name_ff[8]};
               end else if (count_cur != {COUNT_BITS{1'b1}}) begin
                  count_in = count_cur + 1'b1;
               end
            end
            // chain end reports the count including a file judged on this byte
            if (chain_last && !res_valid) begin
               fin_in         = 1'b1;
               res_valid      = 1'b1;
               res.status     = fde_pkg::STATUS_CHAIN_END;
               res.file_count = report_count(count_in);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         first_ff  <= '0;
         attr_ff   <= '0;
         keq_ff    <= 1'b1;
         clu_hi_ff <= '0;
         clu_lo_ff <= '0;
         size_ff   <= '0;
         count_ff  <= '0;
         fin_ff    <= 1'b0;
      end else if (step_en) begin
         pos_ff    <= pos_in;
         first_ff  <= first_in;
         attr_ff   <= attr_in;
         keq_ff    <= keq_in;
         clu_hi_ff <= clu_hi_in;
         clu_lo_ff <= clu_lo_in;
         size_ff   <= size_in;
         count_ff  <= count_in;
         fin_ff    <= fin_in;
      end
   end

   // name bytes, no reset needed
   always_ff @(posedge clock) begin
      for (int i = 0; i < fde_pkg::NAME_BYTES; i++) begin
         if (step_en && !fin_cur && (pos_cur == 5'(i))) begin
            name_ff[i] <= data_byte;
         end
      end
   end

endmodule

/* bench/fat_directory_entry_scan_check.sv */
// checker for the fat directory entry scanner: predicts each result and compares transfers
module fat_directory_entry_scan_check (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] data_byte
   input  logic          req_tuser,   // [0] scan_start
   input  logic          req_tlast,   // chain_last
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [167:0]  rsp_tdata,   // file_count, start_cluster, file_size, name_low, name_high
   input  logic [1:0]    rsp_tuser,   // [1:0] status
   input  logic          csr_we,
   input  logic [1:0]    csr_addr,
   input  logic [63:0]   csr_wdata,
   output int unsigned   mismatches,
   output int unsigned   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import fde_pkg::*;

   // register copies
   logic [1:0]             mode_reg;
   logic [63:0]            key_low_reg;
   logic [23:0]            key_high_reg;
   logic [15:0]            target_reg;

   // scan state
   logic [4:0]             position;
   logic [7:0]             lead_byte;
   logic [7:0]             attr_byte;
   logic                   name_equal;
   logic [15:0]            cluster_hi;
   logic [15:0]            cluster_lo;
   logic [31:0]            size_word;
   logic [7:0]             name_bytes [NAME_BYTES];
   logic [REPORT_BITS-1:0] files_seen;
   logic                   scan_over;

   result_type             scan_reports [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic post_report(input status_type st);
      result_type r;
      r = '0;
      r.status     = st;
      r.file_count = files_seen;
      if (st == STATUS_FOUND) begin
         r.start_cluster = {cluster_hi, cluster_lo};
         r.file_size     = size_word;
         for (int i = 0; i < 8; i++) r.name_low[8*i +: 8] = name_bytes[i];
         for (int i = 0; i < 3; i++) r.name_high[8*i +: 8] = name_bytes[8+i];
      end
      scan_reports.push_back(r);
   endtask

   task automatic advance_scan(input logic [7:0] b, input logic start, input logic last);
      logic [4:0] pos;
      logic [7:0] key_b;
      logic       skip;
      logic       hit;
      logic       stop;
      if (start) begin
         position   = '0;
         files_seen = '0;
         scan_over  = 1'b0;
         name_equal = 1'b1;
      end
      if (!scan_over) begin
         pos      = position;
         position = pos + 5'd1;
         stop     = 1'b0;
         if (pos == POS_FIRST) begin
            lead_byte  = b;
            name_equal = 1'b1;
            if (b == MARK_END) begin
               scan_over = 1'b1;
               stop      = 1'b1;
               post_report(STATUS_END);
            end
         end
         if (!stop) begin
            if (pos < NAME_BYTES) begin
               if (pos < 8) key_b = key_low_reg[8*pos +: 8];
               else key_b = key_high_reg[8*(pos-8) +: 8];
               name_bytes[pos] = b;
               if (b != key_b) name_equal = 1'b0;
            end else if (pos == POS_ATTR) begin
               attr_byte = b;
            end else if (pos == POS_CLU_HI_0) begin
               cluster_hi[7:0] = b;
            end else if (pos == POS_CLU_HI_1) begin
               cluster_hi[15:8] = b;
            end else if (pos == POS_CLU_LO_0) begin
               cluster_lo[7:0] = b;
            end else if (pos == POS_CLU_LO_1) begin
               cluster_lo[15:8] = b;
            end else if (pos >= POS_SIZE_0) begin
               size_word[8*(pos-POS_SIZE_0) +: 8] = b;
            end
            // entry judged on its last byte
            if (pos == POS_LAST) begin
               skip = (lead_byte == MARK_DELETED) || (attr_byte == ATTR_LONG_NAME) ||
                      ((attr_byte & ATTR_SKIP_MASK) != 8'h00);
               if (!skip) begin
                  if (mode_reg == MODE_FIND_NAME) hit = name_equal;
                  else if (mode_reg == MODE_FIND_INDEX) hit = (files_seen == target_reg);
                  else hit = 1'b0;
                  if (hit) begin
                     scan_over = 1'b1;
                     stop      = 1'b1;
                     post_report(STATUS_FOUND);
                  end else if (files_seen != '1) begin
                     files_seen++;
                  end
               end
            end
            if (!stop && last) begin
               scan_over = 1'b1;
               post_report(STATUS_CHAIN_END);
            end
         end
      end
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   task automatic compare_report();
      result_type want;
      if (scan_reports.size() == 0) begin
         $error("result transfer with nothing expected: status %0d", rsp_tuser);
         mismatches++;
      end else begin
         want = scan_reports.pop_front();
         check_field("status", want.status, rsp_tuser);
         check_field("file_count", want.file_count, rsp_tdata[15:0]);
         check_field("start_cluster", want.start_cluster, rsp_tdata[47:16]);
         check_field("file_size", want.file_size, rsp_tdata[79:48]);
         check_field("name_low", want.name_low, rsp_tdata[143:80]);
         check_field("name_high", want.name_high, rsp_tdata[167:144]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_reg     = '0;
         key_low_reg  = '0;
         key_high_reg = '0;
         target_reg   = '0;
         position     = '0;
         lead_byte    = '0;
         attr_byte    = '0;
         name_equal   = 1'b1;
         cluster_hi   = '0;
         cluster_lo   = '0;
         size_word    = '0;
         files_seen   = '0;
         scan_over    = 1'b0;
         for (int i = 0; i < NAME_BYTES; i++) name_bytes[i] = '0;
         scan_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_SEARCH_MODE:   mode_reg     = csr_wdata[1:0];
               REG_NAME_KEY_LOW:  key_low_reg  = csr_wdata;
               REG_NAME_KEY_HIGH: key_high_reg = csr_wdata[23:0];
               REG_TARGET_INDEX:  target_reg   = csr_wdata[15:0];
               default: ;
            endcase
         end
         // older results leave the queue before this edge's byte adds one
         if (rsp_tvalid && rsp_tready) compare_report();
         if (req_tvalid && req_tready) advance_scan(req_tdata, req_tuser, req_tlast);
      end
      outstanding = scan_reports.size();
   end

endmodule

/* bench/fat_directory_entry_scan_test.sv */
// top of the directory scanner bench: stimulus, handshake pacing and verdict
module fat_directory_entry_scan_test;
   timeunit 1ns;
   timeprecision 1ps;
   import fde_pkg::*;

   localparam int RANDOM_ITEMS = 1300;  // bytes in the random part
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int DRAIN_CYCLES = 6;     // idle wait after the last expected result arrives
   localparam int START_BIT    = 8;
   localparam int LAST_BIT     = 9;

   typedef enum int {
      KIND_FILE,
      KIND_KEYED,
      KIND_DELETED,
      KIND_LONG,
      KIND_SKIP_ATTR,
      KIND_NOISE,
      KIND_ONES,
      KIND_LOW
   } entry_kind_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [7:0]    req_tdata;   // [7:0] data_byte
   logic          req_tuser;   // [0] scan_start
   logic          req_tlast;   // chain_last
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [167:0]  rsp_tdata;   // file_count, start_cluster, file_size, name_low, name_high
   logic [1:0]    rsp_tuser;   // [1:0] status
   logic          csr_we;
   logic [1:0]    csr_addr;
   logic [63:0]   csr_wdata;

   int unsigned   mismatches;
   int unsigned   outstanding;

   // shared pacing controls
   int            idle_max = 6;
   bit            hold_request = 1'b0;
   int unsigned   bytes_sent = 0;

   // key currently loaded, used to build matching entries
   logic [63:0]   key_low_now = '0;
   logic [23:0]   key_high_now = '0;

   // bytes of the scan being built: {chain_last, scan_start, data}
   logic [9:0]    scan_q [$];

   fat_directory_entry_scan u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   fat_directory_entry_scan_check u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // one byte transfer, after a random gap with valid low
   task automatic send_byte(input logic [7:0] b, input logic start, input logic last);
      int gap;
      gap = $urandom_range(0, idle_max);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // stop offering, wait for every expected result, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] addr, input logic [63:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
   endtask

   // all four registers, only with the block idle
   task automatic set_config(input logic [1:0] mode, input logic [63:0] klo,
                             input logic [23:0] khi, input logic [15:0] tgt);
      settle();
      write_reg(REG_SEARCH_MODE, {62'd0, mode});
      write_reg(REG_NAME_KEY_LOW, klo);
      write_reg(REG_NAME_KEY_HIGH, {40'd0, khi});
      write_reg(REG_TARGET_INDEX, {48'd0, tgt});
      @(negedge clock);
      csr_we <= 1'b0;
      key_low_now  = klo;
      key_high_now = khi;
   endtask

   // append one 32-byte entry of the given kind
   task automatic add_entry(input entry_kind_type kind);
      logic [7:0]  e [32];
      logic [87:0] key_all;
      key_all = {key_high_now, key_low_now};
      for (int i = 0; i < 32; i++) e[i] = 8'($urandom_range(0, 255));
      // plain file attribute: no skip bits, not the long-name pattern
      e[POS_ATTR] = e[POS_ATTR] & ~ATTR_SKIP_MASK;
      if (e[POS_ATTR] == ATTR_LONG_NAME) e[POS_ATTR] = 8'h20;
      // keep the first byte off the end and deleted marks
      if (e[0] == MARK_END || e[0] == MARK_DELETED) e[0] = e[0] ^ 8'h01;
      case (kind)
         KIND_KEYED: begin
            for (int i = 0; i < NAME_BYTES; i++) e[i] = key_all[8*i +: 8];
         end
         KIND_DELETED: e[0] = MARK_DELETED;
         KIND_LONG: e[POS_ATTR] = ATTR_LONG_NAME;
         KIND_SKIP_ATTR: begin
            // volume label or subdirectory bit, other bits random
            e[POS_ATTR] = 8'($urandom_range(0, 255));
            e[POS_ATTR][3 + $urandom_range(0, 1)] = 1'b1;
         end
         KIND_NOISE: begin
            for (int i = 0; i < 32; i++) e[i] = 8'($urandom_range(0, 255));
         end
         KIND_ONES: begin
            for (int i = 0; i < 32; i++) e[i] = 8'hFF;
            e[POS_ATTR] = 8'h00;
         end
         KIND_LOW: begin
            for (int i = 0; i < 32; i++) e[i] = 8'h00;
            e[0] = 8'h01;
         end
         default: ;
      endcase
      for (int i = 0; i < 32; i++) scan_q.push_back({2'b00, e[i]});
   endtask

   // chain end mark on the newest byte of the scan
   task automatic mark_last();
      logic [9:0] item;
      if (scan_q.size() == 0) scan_q.push_back({2'b00, 8'($urandom_range(1, 255))});
      item = scan_q[scan_q.size() - 1];
      item[LAST_BIT] = 1'b1;
      scan_q[scan_q.size() - 1] = item;
   endtask

   task automatic send_scan(input bit with_start);
      logic [9:0] item;
      if (with_start && scan_q.size() != 0) begin
         item = scan_q[0];
         item[START_BIT] = 1'b1;
         scan_q[0] = item;
      end
      while (scan_q.size() != 0) begin
         item = scan_q.pop_front();
         send_byte(item[7:0], item[START_BIT], item[LAST_BIT]);
      end
   endtask

   // a short directory of random entries, usually closed by an end mark or a chain end
   task automatic random_scan();
      entry_kind_type kind;
      int             term;
      scan_q.delete();
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: kind = KIND_FILE;
            4, 5:       kind = KIND_KEYED;
            6:          kind = KIND_DELETED;
            7:          kind = KIND_LONG;
            8:          kind = KIND_SKIP_ATTR;
            default:    kind = KIND_NOISE;
         endcase
         add_entry(kind);
      end
      term = $urandom_range(0, 9);
      if (term < 4) begin
         // end marker, sometimes on the same byte as a chain end
         scan_q.push_back({1'($urandom_range(0, 1)), 1'b0, MARK_END});
      end else if (term < 7) begin
         mark_last();
      end else begin
         // partial entry, chain end on its last byte or left open as a broken scan
         repeat ($urandom_range(1, 31)) scan_q.push_back({2'b00, 8'($urandom_range(0, 255))});
         if (term < 9) mark_last();
      end
      send_scan($urandom_range(0, 15) != 0);
      // stray bytes, mostly ignored by a finished scan
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 2))
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
   endtask

   // receiver: random stall before each result, one long hold-off on request
   initial begin
      int stall;
      rsp_tready = 1'b1;
      forever begin
         stall = $urandom_range(0, idle_max);
         if (hold_request) begin
            stall = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_tready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // hard stop if the run hangs
   initial begin
      #1_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int unsigned items_mark;
      logic [63:0] klo;
      logic [23:0] khi;
      logic [15:0] tgt;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----

      // after reset a scan runs without a start mark: end marker closes it
      send_byte(MARK_END, 1'b0, 1'b0);
      // finished scan: this byte and its chain end are ignored
      send_byte(8'h41, 1'b0, 1'b1);

      // name search over every kind of skipped entry, then a match
      set_config(MODE_FIND_NAME, 64'h2020_454D_4441_4552, 24'h54_58_54, 16'd0);
      add_entry(KIND_DELETED);
      add_entry(KIND_LONG);
      add_entry(KIND_SKIP_ATTR);
      add_entry(KIND_FILE);
      add_entry(KIND_KEYED);
      scan_q.push_back({2'b00, MARK_END});
      send_scan(1'b1);

      // index search: data byte extremes, second valid file wanted
      set_config(MODE_FIND_INDEX, 64'd0, 24'd0, 16'd1);
      add_entry(KIND_LOW);
      add_entry(KIND_ONES);
      send_scan(1'b1);

      // unused mode counts only; chain end in the middle of an entry
      set_config(2'd3, '1, '1, '1);
      add_entry(KIND_FILE);
      repeat (6) scan_q.push_back({2'b00, 8'($urandom_range(1, 255))});
      mark_last();
      send_scan(1'b1);

      // index never reached: chain end on an entry's last byte, file counted
      set_config(MODE_FIND_INDEX, 64'h0123_4567_89AB_CDEF, 24'hFE_DC_BA, 16'hFFFF);
      add_entry(KIND_FILE);
      add_entry(KIND_FILE);
      mark_last();
      send_scan(1'b1);

      // match on the same byte as a chain end: found stands
      set_config(MODE_FIND_NAME, '1, '1, 16'd0);
      add_entry(KIND_ONES);
      mark_last();
      send_scan(1'b1);

      // end marker on the same byte as a chain end: end stands
      set_config(2'd2, 64'd0, 24'd0, 16'd2);
      scan_q.push_back({2'b00, MARK_END});
      mark_last();
      send_scan(1'b1);

      // ---- back-pressure: receiver holds off while one-byte scans pile up ----
      idle_max = 0;
      hold_request = 1'b1;
      repeat (40) send_byte(MARK_END, 1'b1, 1'b0);
      settle();

      // ---- random part ----
      items_mark = bytes_sent;
      while ((bytes_sent - items_mark) < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: begin
               klo = '1;
               khi = '1;
            end
            1: begin
               klo = '0;
               khi = '0;
            end
            default: begin
               klo = {$urandom, $urandom};
               khi = 24'($urandom);
            end
         endcase
         if ($urandom_range(0, 9) < 8) tgt = 16'($urandom_range(0, 3));
         else tgt = 16'($urandom);
         set_config(2'($urandom_range(0, 3)), klo, khi, tgt);
         // some phases run with no idling on either side
         idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
         repeat ($urandom_range(2, 6)) random_scan();
         settle();
      end

      settle();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/fde_pkg.sv
rtl/core/fde_csr.sv
rtl/core/fde_scan.sv
rtl/core/fat_directory_entry_scan.sv
bench/fat_directory_entry_scan_check.sv
bench/fat_directory_entry_scan_test.sv
